FILE: rtl/lpd_pkg.sv
// shared types, constants and helpers for the length-prefix deframer
package lpd_pkg;

    localparam logic [2:0] MAX_HEADER_BYTES = 3'd4;
    localparam int unsigned ACCUM_W = 32;
    localparam int unsigned LEN_W   = 16;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_LAST   = 3'd2,
        KIND_EMPTY  = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_LENGTH_WIDTH  = 2'd0,
        REG_LSB_FIRST     = 2'd1,
        REG_LENGTH_ADJUST = 2'd2,
        REG_MAX_FRAME_LEN = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]       length_width;
        logic             lsb_first;
        logic signed [8:0] length_adjust;
        logic [LEN_W-1:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
    } res_t;

    // clamp the programmed width into 1..MAX_HEADER_BYTES
    function automatic logic [2:0] eff_width(input logic [2:0] w);
        logic [2:0] r;
        r = w;
        if (r == 3'd0) r = 3'd1;
        if (r > MAX_HEADER_BYTES) r = MAX_HEADER_BYTES;
        return r;
    endfunction

endpackage

FILE: rtl/length_prefix_deframer_top.sv
// length-prefix deframer: one result per received byte
// latency: a result is shown on m_* the cycle after its byte is accepted
// throughput: one byte per clock while m_ready stays high, set by the single result register
// s_ready stays high while the result register is empty or being drained
// reset (aresetn low, synchronous) returns to the header phase and loads
// the register defaults: width 4, big-endian, adjust 0, max length 1024
module length_prefix_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpd_pkg::*;

    cfg_t cfg;
    res_t res;
    logic in_fire;

    // a request is taken when the result register can hold its answer
    assign in_fire = s_valid && s_ready;

    // configuration registers
    lpd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // header gathering, length check and payload counting
    lpd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_fire (in_fire),
        .rx_byte (s_rx_byte),
        .res     (res)
    );

    // result register decouples the consumer from the input side
    lpd_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .res            (res),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte)
    );

endmodule

FILE: rtl/lpd_cfg_regs.sv
// apb register bank holding the deframer configuration
module lpd_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lpd_pkg::cfg_t      cfg
);
    import lpd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length_width     <= 3'd4;
            cfg_reg.lsb_first        <= 1'b0;
            cfg_reg.length_adjust    <= 9'sd0;
            cfg_reg.max_frame_length <= 16'd1024;
        end else if (wr_en) begin
            unique case (idx)
                REG_LENGTH_WIDTH:  cfg_reg.length_width     <= pwdata[2:0];
                REG_LSB_FIRST:     cfg_reg.lsb_first        <= pwdata[0];
                REG_LENGTH_ADJUST: cfg_reg.length_adjust    <= signed'(pwdata[8:0]);
                REG_MAX_FRAME_LEN: cfg_reg.max_frame_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LENGTH_WIDTH:  prdata = {29'd0, cfg_reg.length_width};
            REG_LSB_FIRST:     prdata = {31'd0, cfg_reg.lsb_first};
            REG_LENGTH_ADJUST: prdata = {23'd0, cfg_reg.length_adjust};
            REG_MAX_FRAME_LEN: prdata = {16'd0, cfg_reg.max_frame_length};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/lpd_parser.sv
// header/payload state and the per-byte result logic
module lpd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  lpd_pkg::cfg_t cfg,
    input  logic          in_fire,
    input  logic [7:0]    rx_byte,
    output lpd_pkg::res_t res
);
    import lpd_pkg::*;

    logic               in_payload_reg, in_payload_next;
    logic [2:0]         header_count_reg, header_count_next;
    logic [ACCUM_W-1:0] length_accum_reg, length_accum_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;

    logic [2:0]         width;
    logic [2:0]         cnt;
    logic [1:0]         pos;
    logic [ACCUM_W-1:0] accum;
    logic [ACCUM_W+1:0] len;
    logic               len_neg;
    logic               len_big;
    logic [LEN_W-1:0]   left_dec;

    always_comb begin
        width    = eff_width(cfg.length_width);
        cnt      = header_count_reg + 3'd1;
        pos      = cfg.lsb_first ? header_count_reg[1:0]
                                 : 2'(width - header_count_reg - 3'd1);
        accum    = length_accum_reg;
        if (header_count_reg < width) begin
            accum = length_accum_reg | ({24'd0, rx_byte} << {pos, 3'b000});
        end
        len      = {2'b00, accum} + {{25{cfg.length_adjust[8]}}, cfg.length_adjust};
        len_neg  = len[ACCUM_W+1];
        len_big  = !len_neg && (len[ACCUM_W:0] > {17'd0, cfg.max_frame_length});
        left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        res               = '{kind: KIND_HEADER, payload_byte: 8'd0};

        if (in_payload_reg) begin
            res.payload_byte = rx_byte;
            bytes_left_next  = left_dec;
            if (left_dec == '0) begin
                res.kind          = KIND_LAST;
                in_payload_next   = 1'b0;
                header_count_next = 3'd0;
                length_accum_next = '0;
            end else begin
                res.kind = KIND_DATA;
            end
        end else begin
            header_count_next = cnt;
            length_accum_next = accum;
            if (cnt >= width) begin
                header_count_next = 3'd0;
                length_accum_next = '0;
                priority if (len_neg || len_big) begin
                    res.kind        = KIND_ERROR;
                    bytes_left_next = '0;
                end else if (len == '0) begin
                    res.kind        = KIND_EMPTY;
                    bytes_left_next = '0;
                end else begin
                    res.kind        = KIND_HEADER;
                    in_payload_next = 1'b1;
                    bytes_left_next = len[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= 3'd0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
        end else if (in_fire) begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

FILE: rtl/lpd_out_reg.sv
// result register with valid/ready handshake toward the consumer
module lpd_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lpd_pkg::res_t res,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_kind,
    output logic [7:0]    m_payload_byte
);
    import lpd_pkg::*;

    logic m_valid_reg;
    res_t res_reg;

    assign s_ready        = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_payload_byte = res_reg.payload_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/lpd_checker.sv
// port-level checks for the deframer, bound to the top level
module lpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [7:0]  m_payload_byte
);
    import lpd_pkg::*;

    // held result stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_payload_byte))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // every accepted byte yields a result next cycle
    a_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted byte gave no result");

    // an empty result register never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // non-payload results carry a zero byte
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_DATA && m_kind != KIND_LAST |-> m_payload_byte == 8'd0)
        else $error("payload byte on non-payload result");

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_payload_byte (m_payload_byte)
);

FILE: tb/length_prefix_deframer_top_tb.sv
// self-checking testbench for the length-prefix deframer with a cycle-free predictor
module length_prefix_deframer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request accepted anywhere
    localparam int RANDOM_ITEMS   = 850;
    localparam int PHASE_ITEMS    = 60;

    // predicts one result per received byte and checks results in order
    class deframe_scoreboard;
        // register copy
        logic [2:0]        length_width;
        logic              lsb_first;
        logic signed [8:0] length_adjust;
        logic [15:0]       max_frame_length;
        // frame state
        logic              in_payload;
        logic [2:0]        header_count;
        logic [31:0]       length_accum;
        logic [15:0]       bytes_left;
        res_t              pending_results[$];
        int                mismatches;

        function new();
            length_width     = 3'd4;
            lsb_first        = 1'b0;
            length_adjust    = 9'sd0;
            max_frame_length = 16'd1024;
            mismatches       = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            in_payload   = 1'b0;
            header_count = 3'd0;
            length_accum = 32'd0;
            bytes_left   = 16'd0;
        endfunction

        // programmed width folded into 1..4
        function int active_width();
            int w;
            w = int'(length_width);
            if (w < 1) w = 1;
            if (w > 4) w = 4;
            return w;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_LENGTH_WIDTH:  length_width     = value[2:0];
                REG_LSB_FIRST:     lsb_first        = value[0];
                REG_LENGTH_ADJUST: length_adjust    = value[8:0];
                REG_MAX_FRAME_LEN: max_frame_length = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_rx_byte(logic [7:0] rx);
            int     w;
            int     cnt;
            int     pos;
            longint frame_len;
            res_t   r;
            r.kind         = KIND_HEADER;
            r.payload_byte = 8'h00;
            if (in_payload) begin
                r.payload_byte = rx;
                if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    r.kind = KIND_LAST;
                    restart_frame();
                end else begin
                    r.kind = KIND_DATA;
                end
            end else begin
                w   = active_width();
                cnt = int'(header_count);
                // bytes past a lowered width only count, they are not placed
                if (cnt < w) begin
                    pos          = lsb_first ? cnt : (w - cnt - 1);
                    length_accum = length_accum | (32'(rx) << (8 * pos));
                end
                cnt++;
                header_count = 3'(cnt);
                if (cnt >= w) begin
                    frame_len = longint'(length_accum) + longint'(int'(length_adjust));
                    if (frame_len < 0 || frame_len > longint'(max_frame_length)) begin
                        r.kind = KIND_ERROR;
                        restart_frame();
                    end else if (frame_len == 0) begin
                        r.kind = KIND_EMPTY;
                        restart_frame();
                    end else begin
                        in_payload   = 1'b1;
                        header_count = 3'd0;
                        length_accum = 32'd0;
                        bytes_left   = frame_len[15:0];
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] payload);
            res_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got kind %0d byte %02h",
                         $time, kind, payload);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                mismatches++;
                $display("%0t: kind mismatch, expected %0d, got %0d",
                         $time, want.kind, kind);
            end
            if (payload !== want.payload_byte) begin
                mismatches++;
                $display("%0t: payload_byte mismatch, expected %02h, got %02h",
                         $time, want.payload_byte, payload);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deframe_scoreboard sb = new();
    int rx_count;      // accepted input requests
    int quiet_cycles;  // watchdog counter
    bit steady;        // when set neither side idles

    length_prefix_deframer_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // gap length shared by sender idles and receiver stalls: mostly none,
    // some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one byte request; returns at the edge that accepted it, then maybe idles
    task automatic send_byte(logic [7:0] value);
        int gap;
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_rx_byte(value);
        rx_count++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the sender until every expected result is out, plus the
    // result latency with margin
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // apb write: setup phase, access phase, then an idle wait with psel low so back-to-back
    // writes never drive psel twice in one step
    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic program_setting(int width, int little, int adjust, int max_len);
        apb_write(REG_LENGTH_WIDTH, 32'(width));
        apb_write(REG_LSB_FIRST, 32'(little));
        apb_write(REG_LENGTH_ADJUST, 32'(adjust));
        apb_write(REG_MAX_FRAME_LEN, 32'(max_len));
    endtask

    // one frame: a length header aimed at a small legal payload most of the
    // time, random header bytes otherwise, then payload until the frame closes
    task automatic send_frame();
        int     w;
        int     choice;
        int     target;
        int     i;
        longint fit_max;
        longint hdr;
        longint legal_len;
        w       = sb.active_width();
        fit_max = (longint'(1) << (8 * w)) - 1;
        choice  = $urandom_range(0, 99);
        if (choice < 12) begin
            hdr       = longint'($urandom) & fit_max;
            legal_len = hdr + longint'(int'(sb.length_adjust));
            // keep accidental legal lengths from turning into huge frames
            if (legal_len > 600 && legal_len <= longint'(sb.max_frame_length))
                hdr = hdr & 64'hFF;
        end else begin
            target = (choice < 80) ? $urandom_range(0, 12) : $urandom_range(13, 40);
            target = target % (int'(sb.max_frame_length) + 1);
            hdr    = longint'(target) - longint'(int'(sb.length_adjust));
            if (hdr < 0 || hdr > fit_max) hdr = $urandom_range(0, 255);
        end
        for (i = 0; i < w; i++) begin
            if (sb.lsb_first) send_byte(hdr[8*i +: 8]);
            else send_byte(hdr[8*(w-1-i) +: 8]);
        end
        while (sb.in_payload) send_byte(8'($urandom_range(0, 255)));
    endtask

    // result side: check every accepted result, stall at random
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_kind, m_payload_byte);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // watchdog: any accepted request on any port restarts the count
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // main stimulus
    initial begin
        int phase;
        int stop_at;
        int phase_end;
        int r;
        int width_sel;
        int little_sel;
        int adjust_sel;
        int max_sel;

        // every input known from time zero
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 4'd0;
        pwdata    = 32'd0;
        rx_count  = 0;
        steady    = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part, reset defaults: 4-byte big-endian header ---
        // two-byte frame with the payload byte extremes
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h02);
        send_byte(8'h00); send_byte(8'hFF);
        // zero length gives an empty frame
        repeat (4) send_byte(8'h00);
        // largest header value is far above the maximum: length error
        repeat (4) send_byte(8'hFF);

        // width lowered while a header is half gathered: the next byte
        // completes the header without being placed
        send_byte(8'h00); send_byte(8'h05);
        wait_drained();
        apb_write(REG_LENGTH_WIDTH, 32'd1);
        send_byte(8'h07);

        // width 0 acts as 1; adjust -255 gives empty then negative length
        wait_drained();
        program_setting(0, 1, -255, 1024);
        send_byte(8'hFF);
        send_byte(8'h00);

        // width above the limit acts as 4; max length 0 rejects everything nonzero
        wait_drained();
        program_setting(7, 1, 255, 0);
        repeat (4) send_byte(8'h00);

        // --- random part: phases of framed traffic under changing settings ---
        stop_at = rx_count + RANDOM_ITEMS;
        phase   = 0;
        while (rx_count < stop_at) begin
            wait_drained();
            case (phase)
                0: begin
                    width_sel = 1; little_sel = 0; adjust_sel = 255; max_sel = 65535;
                end
                1: begin
                    width_sel = 2; little_sel = 1; adjust_sel = -255; max_sel = 0;
                end
                2: begin
                    width_sel = 3; little_sel = 0; adjust_sel = 0; max_sel = 1024;
                end
                3: begin
                    width_sel = 4; little_sel = 1; adjust_sel = -3; max_sel = 65535;
                end
                default: begin
                    width_sel  = $urandom_range(0, 7);
                    little_sel = $urandom_range(0, 1);
                    r = $urandom_range(0, 99);
                    if (r < 15) adjust_sel = -255;
                    else if (r < 30) adjust_sel = 255;
                    else if (r < 55) adjust_sel = $urandom_range(0, 10) - 5;
                    else adjust_sel = $urandom_range(0, 510) - 255;
                    r = $urandom_range(0, 99);
                    if (r < 10) max_sel = 0;
                    else if (r < 25) max_sel = 65535;
                    else if (r < 50) max_sel = $urandom_range(1, 20);
                    else max_sel = $urandom_range(21, 2000);
                end
            endcase
            program_setting(width_sel, little_sel, adjust_sel, max_sel);
            // some phases run with no idling at all
            steady    = (phase % 5 == 2);
            phase_end = rx_count + PHASE_ITEMS;
            while (rx_count < phase_end && rx_count < stop_at) begin
                send_frame();
                // now and then the sender holds off until all results are out
                if ($urandom_range(0, 39) == 0) wait_drained();
            end
            phase++;
        end

        // wait out the last results and the result latency
        steady = 1'b0;
        wait_drained();
        repeat (5) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
